// ===== rtl/pss_pkg.sv =====
// Shared widths, codes, reset values and a duty saturation helper for the PWM soft-start ramp.
package pss_pkg;

  localparam int DUTY_W    = 7;
  localparam int TIME_W    = 16;
  localparam int DIV_W     = 16;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam int STATUS_W  = 2;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  localparam logic [7:0] DUTY_FULL_SCALE = 8'd100;

  localparam logic [TIME_W-1:0] RISE_TIME_RST  = 16'd2000;
  localparam logic [TIME_W-1:0] FALL_TIME_RST  = 16'd1000;
  localparam logic [DUTY_W-1:0] START_FLOOR_RST = 7'd11;
  localparam logic              RESTART_RST     = 1'b1;

  localparam logic [STATUS_W-1:0] ST_RAMPING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SETTLED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STALLED = 2'd2;

  localparam logic [1:0] REG_RISE_TIME   = 2'd0;
  localparam logic [1:0] REG_FALL_TIME   = 2'd1;
  localparam logic [1:0] REG_START_FLOOR = 2'd2;
  localparam logic [1:0] REG_RESTART     = 2'd3;

  localparam logic [1:0] OP_ARM     = 2'd0;
  localparam logic [1:0] OP_QUOT_UP = 2'd1;
  localparam logic [1:0] OP_QUOT_DN = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] rise_time_ms;
    logic [TIME_W-1:0] fall_time_ms;
    logic [DUTY_W-1:0] start_floor;
    logic              restart_on_change;
  } cfg_t;

  function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] v);
    if ({1'b0, v} > DUTY_FULL_SCALE) begin
      return DUTY_FULL_SCALE[DUTY_W-1:0];
    end
    return v;
  endfunction

endpackage

// ===== rtl/pss_ifs.sv =====
// Valid/ready channel interfaces for the ramp input and result words.
interface pss_in_if;
  import pss_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] target_duty;

  modport source (output valid, output target_duty, input ready);
  modport sink   (input valid, input target_duty, output ready);
endinterface

interface pss_out_if;
  import pss_pkg::*;
  logic                valid;
  logic                ready;
  logic [DUTY_W-1:0]   duty_out;
  logic [STATUS_W-1:0] ramp_status;
  logic                drive_on;

  modport source (output valid, output duty_out, output ramp_status, output drive_on,
                  input ready);
  modport sink   (input valid, input duty_out, input ramp_status, input drive_on,
                  output ready);
endinterface

// ===== rtl/pss_cfg_regs.sv =====
// APB-style configuration registers of the ramp.
module pss_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pss_pkg::CFG_AW-1:0] paddr,
  input  logic [pss_pkg::CFG_DW-1:0] pwdata,
  output logic [pss_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output pss_pkg::cfg_t             cfg
);
  import pss_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_RISE_TIME:   cfg_nxt.rise_time_ms      = pwdata[TIME_W-1:0];
        REG_FALL_TIME:   cfg_nxt.fall_time_ms      = pwdata[TIME_W-1:0];
        REG_START_FLOOR: cfg_nxt.start_floor       = pwdata[DUTY_W-1:0];
        REG_RESTART:     cfg_nxt.restart_on_change = pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RISE_TIME:   prdata = {{(CFG_DW-TIME_W){1'b0}}, cfg_r.rise_time_ms};
      REG_FALL_TIME:   prdata = {{(CFG_DW-TIME_W){1'b0}}, cfg_r.fall_time_ms};
      REG_START_FLOOR: prdata = {{(CFG_DW-DUTY_W){1'b0}}, cfg_r.start_floor};
      REG_RESTART:     prdata = {{(CFG_DW-1){1'b0}}, cfg_r.restart_on_change};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rise_time_ms      <= RISE_TIME_RST;
      cfg_r.fall_time_ms      <= FALL_TIME_RST;
      cfg_r.start_floor       <= START_FLOOR_RST;
      cfg_r.restart_on_change <= RESTART_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/pss_serial_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module pss_serial_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [pss_pkg::DIV_W-1:0] dividend,
  input  logic [pss_pkg::DIV_W-1:0] divisor,
  output logic                     done,
  output logic [pss_pkg::DIV_W-1:0] quotient
);
  import pss_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_W:0]       rem_shift;
  logic [DIV_W:0]       diff;

  assign rem_shift = {rem_r, quo_r[DIV_W-1]};
  assign diff      = rem_shift - {1'b0, dsr_r};
  assign done      = done_r;
  assign quotient  = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[DIV_W]) begin
        rem_nxt = diff[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_shift[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

// ===== rtl/pwm_soft_start_ramp.sv =====
// PWM duty soft-start ramp: tick sequencer, ramp state and result register.
//
//   channel  dir  handshake        payload
//   in_if    in   valid/ready      target_duty[6:0]
//   out_if   out  valid/ready      duty_out[6:0], ramp_status[1:0], drive_on
//   apb      in   psel/penable     paddr[3:2] selects register, pwdata/prdata 32b
//
// One word at a time: a word is accepted, evaluated and loaded into the output
// register; where a division is needed, evaluation starts the bit-serial divider
// and the output load follows its done. Synchronous active-low reset clears the
// sequencer state, ramp progress and output valid and loads the config registers
// with their reset values. A result waiting in the output register does not block
// the next accept; only the load of the following result waits for out_if.ready.
module pwm_soft_start_ramp (
  input  logic                       clk,
  input  logic                       rst_n,
  pss_in_if.sink                     in_if,
  pss_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pss_pkg::CFG_AW-1:0] paddr,
  input  logic [pss_pkg::CFG_DW-1:0] pwdata,
  output logic [pss_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import pss_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  cfg_t cfg;

  logic [1:0]          state_r, state_nxt;
  logic [DUTY_W-1:0]   t_r, t_nxt;
  logic [1:0]          op_r, op_nxt;
  logic                down_r, down_nxt;
  logic [DUTY_W-1:0]   cur_r, cur_nxt;
  logic [DUTY_W-1:0]   prev_r, prev_nxt;
  logic                rise_r, rise_nxt;
  logic                fall_r, fall_nxt;
  logic [TIME_W-1:0]   interval_r, interval_nxt;
  logic [DUTY_W-1:0]   origin_r, origin_nxt;
  logic [TIME_W-1:0]   ticks_r, ticks_nxt;
  logic                drive_r, drive_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]   out_duty_r, out_duty_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_drive_r, out_drive_nxt;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_q;

  logic                restart_hit;
  logic                rise_eff;
  logic                fall_eff;
  logic                up;
  logic [DUTY_W-1:0]   lo;
  logic [TIME_W-1:0]   ticks_inc;
  logic [DIV_W:0]      v_up;

  pss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pss_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_if.ready        = (state_r == S_IDLE);
  assign out_if.valid       = out_valid_r;
  assign out_if.duty_out    = out_duty_r;
  assign out_if.ramp_status = out_status_r;
  assign out_if.drive_on    = out_drive_r;

  assign restart_hit = cfg.restart_on_change & (t_r != prev_r);
  assign rise_eff    = rise_r & ~restart_hit;
  assign fall_eff    = fall_r & ~restart_hit;
  assign up          = (t_r >= cur_r);
  assign lo          = (cur_r == '0) ? sat_duty(cfg.start_floor) : cur_r;
  assign ticks_inc   = (ticks_r == '1) ? ticks_r : ticks_r + 1'b1;
  assign v_up        = {1'b0, div_q} + {{(DIV_W-DUTY_W+1){1'b0}}, origin_r};

  always_comb begin
    state_nxt      = state_r;
    t_nxt          = t_r;
    op_nxt         = op_r;
    down_nxt       = down_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    rise_nxt       = rise_r;
    fall_nxt       = fall_r;
    interval_nxt   = interval_r;
    origin_nxt     = origin_r;
    ticks_nxt      = ticks_r;
    drive_nxt      = drive_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r & ~out_if.ready;
    out_duty_nxt   = out_duty_r;
    out_status_nxt = out_status_r;
    out_drive_nxt  = out_drive_r;
    div_start      = 1'b0;
    div_dividend   = '0;
    div_divisor    = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_if.valid) begin
          t_nxt     = sat_duty(in_if.target_duty);
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        prev_nxt  = t_r;
        drive_nxt = drive_r | (t_r != '0);
        down_nxt  = ~up;
        if (up) begin
          fall_nxt = 1'b0;
          if (t_r <= lo) begin
            cur_nxt    = t_r;
            rise_nxt   = 1'b0;
            status_nxt = ST_SETTLED;
            state_nxt  = S_OUT;
          end else if (!rise_eff) begin
            rise_nxt     = 1'b1;
            ticks_nxt    = '0;
            origin_nxt   = lo;
            op_nxt       = OP_ARM;
            div_start    = 1'b1;
            div_dividend = cfg.rise_time_ms;
            div_divisor  = {{(DIV_W-DUTY_W){1'b0}}, t_r - lo};
            state_nxt    = S_DIV;
          end else begin
            ticks_nxt = ticks_inc;
            if (interval_r == '0) begin
              rise_nxt   = 1'b0;
              status_nxt = ST_STALLED;
              state_nxt  = S_OUT;
            end else begin
              op_nxt       = OP_QUOT_UP;
              div_start    = 1'b1;
              div_dividend = ticks_inc;
              div_divisor  = interval_r;
              state_nxt    = S_DIV;
            end
          end
        end else begin
          rise_nxt = 1'b0;
          if (!fall_eff) begin
            fall_nxt     = 1'b1;
            ticks_nxt    = '0;
            origin_nxt   = cur_r;
            op_nxt       = OP_ARM;
            div_start    = 1'b1;
            div_dividend = cfg.fall_time_ms;
            div_divisor  = {{(DIV_W-DUTY_W){1'b0}}, cur_r - t_r};
            state_nxt    = S_DIV;
          end else begin
            ticks_nxt = ticks_inc;
            if (interval_r == '0) begin
              fall_nxt   = 1'b0;
              status_nxt = ST_STALLED;
              if (t_r == '0) begin
                drive_nxt = 1'b0;
              end
              state_nxt = S_OUT;
            end else begin
              op_nxt       = OP_QUOT_DN;
              div_start    = 1'b1;
              div_dividend = ticks_inc;
              div_divisor  = interval_r;
              state_nxt    = S_DIV;
            end
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_OUT;
          case (op_r)
            OP_ARM: begin
              interval_nxt = div_q;
              if (div_q == '0) begin
                rise_nxt   = 1'b0;
                fall_nxt   = 1'b0;
                status_nxt = ST_STALLED;
                if (down_r && (t_r == '0)) begin
                  drive_nxt = 1'b0;
                end
              end else begin
                cur_nxt    = origin_r;
                status_nxt = ST_RAMPING;
              end
            end
            OP_QUOT_UP: begin
              if (v_up >= {{(DIV_W-DUTY_W+1){1'b0}}, t_r}) begin
                cur_nxt    = t_r;
                rise_nxt   = 1'b0;
                status_nxt = ST_SETTLED;
              end else begin
                cur_nxt    = v_up[DUTY_W-1:0];
                status_nxt = ST_RAMPING;
              end
            end
            default: begin
              if ((origin_r <= t_r) ||
                  (div_q >= {{(DIV_W-DUTY_W){1'b0}}, origin_r - t_r})) begin
                cur_nxt    = t_r;
                fall_nxt   = 1'b0;
                status_nxt = ST_SETTLED;
                if (t_r == '0) begin
                  drive_nxt = 1'b0;
                end
              end else begin
                cur_nxt    = origin_r - div_q[DUTY_W-1:0];
                status_nxt = ST_RAMPING;
              end
            end
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_duty_nxt   = cur_r;
          out_status_nxt = status_r;
          out_drive_nxt  = drive_r;
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      prev_r      <= '0;
      rise_r      <= 1'b0;
      fall_r      <= 1'b0;
      interval_r  <= '0;
      origin_r    <= '0;
      ticks_r     <= '0;
      drive_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      rise_r      <= rise_nxt;
      fall_r      <= fall_nxt;
      interval_r  <= interval_nxt;
      origin_r    <= origin_nxt;
      ticks_r     <= ticks_nxt;
      drive_r     <= drive_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r          <= t_nxt;
    op_r         <= op_nxt;
    down_r       <= down_nxt;
    status_r     <= status_nxt;
    out_duty_r   <= out_duty_nxt;
    out_status_r <= out_status_nxt;
    out_drive_r  <= out_drive_nxt;
  end

endmodule

// ===== rtl/pss_checker.sv =====
// Port-level assertions for the ramp, bound to the top level.
module pss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [pss_pkg::DUTY_W-1:0]   out_duty,
  input logic [pss_pkg::STATUS_W-1:0] out_status,
  input logic                         out_drive
);

  a_reset_no_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while a word is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty) &&
    $stable(out_status) && $stable(out_drive))
    else $error("stalled result word changed");

  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word appeared without a word in work");

endmodule

bind pwm_soft_start_ramp pss_checker u_pss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_duty   (out_if.duty_out),
  .out_status (out_if.ramp_status),
  .out_drive  (out_if.drive_on)
);
